### rtl/ips_pkg.sv
package ips_pkg;

    // avalanche constants
    localparam logic [63:0] PremixGolden = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] AvalMulA     = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] AvalMulB     = 64'hc4ce_b9fe_1a85_ec53;
    localparam int unsigned XorShift     = 33;
    localparam int unsigned PremixShl    = 6;
    localparam int unsigned PremixShr    = 2;

    // field widths
    localparam int unsigned HashW  = 64;
    localparam int unsigned CountW = 7;
    localparam int unsigned IndexW = 6;
    localparam int unsigned CfgIdxW = 8;

    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    typedef logic [HashW-1:0]   hash_t;
    typedef logic [CountW-1:0]  count_t;
    typedef logic [IndexW-1:0]  index_t;

    // register indexes
    localparam cfg_idx_t RegStrategy   = 8'd0;
    localparam cfg_idx_t RegHashSeed   = 8'd1;
    localparam cfg_idx_t RegPointCount = 8'd2;

    // strategy codes
    localparam logic [1:0] StratRoundRobin = 2'd0;
    localparam logic [1:0] StratHashSrc    = 2'd1;
    localparam logic [1:0] StratHashTuple  = 2'd2;
    localparam logic [1:0] StratUnused     = 2'd3;

    typedef struct packed {
        logic   none;
        count_t pick;
    } result_t;

endpackage

### rtl/ingress_point_selector.sv
// channel | ports                        | direction | beat
// --------+------------------------------+-----------+-----------------------------
// s_      | s_valid s_ready s_flow_*     | in        | one flow request
// m_      | m_valid m_ready m_point_*    | out       | one selection
// cfg_    | cfg_valid cfg_ready cfg_*    | in        | one register write
//
// Hash request: three pre-mix steps, then xor-shift and multiply in turn (three xor-shifts,
// two multiplies on one shared 32x32 multiplier), a 64-step modulo and a finish step.
// Round robin goes straight to the modulo; a zero count or code 3 goes straight to finish.
// s_ready is high only while the sequencer sits idle; a waiting result does not block
// the next accept, only the finish of the following one.
// aresetn is synchronous; it clears the registers, the turn counter and the control.
module ingress_point_selector #(
    parameter int MAX_POINTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ips_pkg::hash_t    s_flow_key_hash,
    output logic              m_valid,
    input  logic              m_ready,
    output ips_pkg::index_t   m_point_index,
    output logic              m_none_available,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  ips_pkg::cfg_idx_t cfg_index,
    input  ips_pkg::hash_t    cfg_data
);
    import ips_pkg::*;

    localparam logic [10:0] MaxPts = MAX_POINTS[10:0];

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StPreA = 4'd1;
    localparam logic [3:0] StPreB = 4'd2;
    localparam logic [3:0] StPreC = 4'd3;
    localparam logic [3:0] StXs   = 4'd4;
    localparam logic [3:0] StMul  = 4'd5;
    localparam logic [3:0] StDiv  = 4'd6;
    localparam logic [3:0] StFin  = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  strategy_reg;
    hash_t       seed_reg;
    count_t      count_reg;
    hash_t       turn_reg, turn_next;
    hash_t       v_reg, v_next;
    hash_t       acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  rnd_reg, rnd_next;
    logic [5:0]  cnt_reg, cnt_next;
    count_t      rem_reg, rem_next;
    count_t      n_reg, n_next;
    result_t     res_reg, res_next;
    logic        m_valid_reg;
    index_t      m_index_reg;
    logic        m_none_reg;

    count_t      n_eff;
    hash_t       mul_const;
    logic [31:0] mul_a, mul_b;
    logic [7:0]  div_trial;
    logic        out_free;

    assign s_ready          = (state_reg == StIdle);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_point_index    = m_index_reg;
    assign m_none_available = m_none_reg;
    assign out_free         = !m_valid_reg || m_ready;

    // saturate the configured count at capacity
    assign n_eff = ({4'b0, count_reg} > MaxPts) ? MaxPts[CountW-1:0] : count_reg;

    // shared multiplier operand select: lo*lo, lo*hi, hi*lo
    assign mul_const = (rnd_reg == 2'd1) ? AvalMulA : AvalMulB;
    assign mul_a     = (phase_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b     = (phase_reg == 2'd1) ? mul_const[63:32] : mul_const[31:0];

    assign div_trial = {rem_reg, v_reg[63]};

    always_comb begin
        state_next = state_reg;
        turn_next  = turn_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        unique case (state_reg)
            StIdle: begin
                if (s_valid) begin
                    n_next   = n_eff;
                    v_next   = s_flow_key_hash;
                    rem_next = '0;
                    cnt_next = '0;
                    rnd_next = '0;
                    res_next = '{none: 1'b0, pick: '0};
                    if (n_eff == '0) begin
                        res_next.none = 1'b1;
                        state_next    = StFin;
                    end else begin
                        case (strategy_reg) inside
                            StratRoundRobin: begin
                                v_next     = turn_reg;
                                turn_next  = turn_reg + 64'd1;
                                state_next = StDiv;
                            end
                            StratHashSrc, StratHashTuple: begin
                                state_next = StPreA;
                            end
                            default: begin
                                state_next = StFin;
                            end
                        endcase
                    end
                end
            end
            StPreA: begin
                acc_next   = seed_reg + PremixGolden;
                state_next = StPreB;
            end
            StPreB: begin
                acc_next   = acc_reg + (v_reg << PremixShl);
                state_next = StPreC;
            end
            StPreC: begin
                v_next     = v_reg ^ (acc_reg + (v_reg >> PremixShr));
                state_next = StXs;
            end
            StXs: begin
                v_next     = v_reg ^ (v_reg >> XorShift);
                rnd_next   = rnd_reg + 2'd1;
                phase_next = '0;
                state_next = (rnd_reg == 2'd2) ? StDiv : StMul;
            end
            StMul: begin
                // low 64 bits of v * const from three partial products
                prod_next  = 64'(mul_a) * 64'(mul_b);
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd0: acc_next = '0;
                    2'd1: acc_next = acc_reg + prod_reg;
                    2'd2: acc_next = acc_reg + {prod_reg[31:0], 32'b0};
                    default: begin
                        v_next     = acc_reg + {prod_reg[31:0], 32'b0};
                        state_next = StXs;
                    end
                endcase
            end
            StDiv: begin
                // restoring modulo, one dividend bit per cycle
                v_next   = v_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (div_trial >= {1'b0, n_reg}) begin
                    rem_next = CountW'(div_trial - {1'b0, n_reg});
                end else begin
                    rem_next = div_trial[CountW-1:0];
                end
                if (cnt_reg == 6'd63) begin
                    res_next.pick = rem_next;
                    state_next    = StFin;
                end
            end
            StFin: begin
                if (out_free) begin
                    state_next = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= StIdle;
            strategy_reg <= '0;
            seed_reg     <= '0;
            count_reg    <= '0;
            turn_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            turn_reg  <= turn_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    RegStrategy:   strategy_reg <= cfg_data[1:0];
                    RegHashSeed:   seed_reg     <= cfg_data;
                    RegPointCount: count_reg    <= cfg_data[CountW-1:0];
                    default: ;
                endcase
            end
            if (state_reg == StFin && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        v_reg     <= v_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        phase_reg <= phase_next;
        rnd_reg   <= rnd_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        n_reg     <= n_next;
        res_reg   <= res_next;
        if (state_reg == StFin && out_free) begin
            m_index_reg <= res_reg.pick[IndexW-1:0];
            m_none_reg  <= res_reg.none;
        end
    end

    a_rr_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && strategy_reg == StratRoundRobin && n_eff != '0)
        |=> (turn_reg == $past(turn_reg) + 64'd1))
        else $error("turn counter did not advance on round-robin request");

    a_turn_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != StIdle) |=> $stable(turn_reg))
        else $error("turn counter moved while busy");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == StDiv && cnt_reg != 6'd0) |-> (rem_reg < n_reg))
        else $error("modulo remainder out of range");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_none_available) |-> (m_point_index == '0))
        else $error("nonzero index with no point available");

    a_fin_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == StFin && out_free) |=> (m_valid && state_reg == StIdle))
        else $error("finished result not loaded");

endmodule
